// File: rtl/core/dpf_pkg.sv
// Package with shared constants, types and command/status structs for the factorizer.
`timescale 1ns / 1ps

package dpf_pkg;

    // Width of the value to factor and of each emitted factor.
    localparam int N_WIDTH     = 32;
    // Upper bound on factors emitted for one value.
    localparam int MAX_RESULTS = 9;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int DIV_CNT_W   = $clog2(N_WIDTH + 1);
    // Input and output data buses are padded to whole bytes.
    localparam int TDATA_W     = ((N_WIDTH + 7) / 8) * 8;

    // Source of the factor handed to the pending register.
    typedef enum logic [1:0] {
        EMIT_ONE = 2'd0,
        EMIT_TWO = 2'd1,
        EMIT_D   = 2'd2,
        EMIT_REM = 2'd3
    } t_emit_sel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      load;
        logic      shift;
        logic      emit;
        t_emit_sel emit_sel;
        logic      rem_q;
        logic      d_inc;
        logic      div_start;
        logic      flush;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic rem_zero;
        logic rem_one;
        logic rem_even;
        logic rem_gt2;
        logic div_busy;
        logic div_done;
        logic d_gt_q;
        logic r_zero;
        logic pend_v;
        logic can_emit;
        logic cap_next;
    } t_sts;

endpackage

// File: rtl/core/dpf_div.sv
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module dpf_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [dpf_pkg::N_WIDTH-1:0] i_dividend,
    input  logic [dpf_pkg::N_WIDTH-1:0] i_divisor,
    output logic                        o_busy,
    output logic                        o_done,
    output logic [dpf_pkg::N_WIDTH-1:0] o_quotient,
    output logic [dpf_pkg::N_WIDTH-1:0] o_remainder
);
    import dpf_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [N_WIDTH-1:0]   r_acc;
    logic [N_WIDTH-1:0]   r_q;
    logic [N_WIDTH-1:0]   r_dvs;
    logic [N_WIDTH:0]     trial;
    logic [N_WIDTH:0]     diff;

    // Bring down the next dividend bit and try to subtract the divisor.
    assign trial = {r_acc, r_q[N_WIDTH-1]};
    assign diff  = trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + DIV_CNT_W'(1);
            if (r_cnt == DIV_CNT_W'(N_WIDTH - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_q   <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            if (!diff[N_WIDTH]) begin
                r_acc <= diff[N_WIDTH-1:0];
                r_q   <= {r_q[N_WIDTH-2:0], 1'b1};
            end else begin
                r_acc <= trial[N_WIDTH-1:0];
                r_q   <= {r_q[N_WIDTH-2:0], 1'b0};
            end
        end
    end

    assign o_busy      = r_busy;
    assign o_done      = r_done;
    assign o_quotient  = r_q;
    assign o_remainder = r_acc;

endmodule

// File: rtl/core/dpf_dpath.sv
// Datapath: remaining value, trial divisor, divider, pending factor and output register.
`timescale 1ns / 1ps

module dpf_dpath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  dpf_pkg::t_cmd               i_cmd,
    output dpf_pkg::t_sts               o_sts,
    input  logic [dpf_pkg::N_WIDTH-1:0] i_value,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [dpf_pkg::TDATA_W-1:0] o_m_tdata,
    output logic                        o_m_tlast
);
    import dpf_pkg::*;

    logic [N_WIDTH-1:0] r_rem;
    logic [N_WIDTH-1:0] r_d;
    logic [N_WIDTH-1:0] r_pend;
    logic               r_pend_v;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_out_v;
    logic [N_WIDTH-1:0] r_out_data;
    logic               r_out_last;

    logic [N_WIDTH-1:0] quotient;
    logic [N_WIDTH-1:0] remainder;
    logic               div_busy;
    logic               div_done;
    logic [N_WIDTH-1:0] emit_val;
    logic               out_free;
    logic               push;

    dpf_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (r_rem),
        .i_divisor   (r_d),
        .o_busy      (div_busy),
        .o_done      (div_done),
        .o_quotient  (quotient),
        .o_remainder (remainder)
    );

    always_comb begin
        unique case (i_cmd.emit_sel)
            EMIT_ONE: emit_val = N_WIDTH'(1);
            EMIT_TWO: emit_val = N_WIDTH'(2);
            EMIT_D:   emit_val = r_d;
            EMIT_REM: emit_val = r_rem;
            default:  emit_val = r_rem;
        endcase
    end

    assign out_free = !r_out_v || i_m_tready;
    // The pending factor moves out when a newer one arrives or the run ends.
    assign push     = (i_cmd.emit && r_pend_v) || i_cmd.flush;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem <= i_value;
            r_d   <= N_WIDTH'(3);
        end else begin
            if (i_cmd.shift) begin
                r_rem <= r_rem >> 1;
            end else if (i_cmd.rem_q) begin
                r_rem <= quotient;
            end
            if (i_cmd.d_inc) begin
                r_d <= r_d + N_WIDTH'(2);
            end
        end
        if (i_cmd.emit) begin
            r_pend <= emit_val;
        end
        if (push) begin
            r_out_data <= r_pend;
            r_out_last <= i_cmd.flush;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_cnt    <= '0;
            r_out_v  <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_pend_v <= 1'b0;
                r_cnt    <= '0;
            end else if (i_cmd.emit) begin
                r_pend_v <= 1'b1;
                r_cnt    <= r_cnt + CNT_W'(1);
            end else if (i_cmd.flush) begin
                r_pend_v <= 1'b0;
            end
            if (push) begin
                r_out_v <= 1'b1;
            end else if (r_out_v && i_m_tready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_sts.rem_zero = (r_rem == '0);
    assign o_sts.rem_one  = (r_rem == N_WIDTH'(1));
    assign o_sts.rem_even = !r_rem[0];
    assign o_sts.rem_gt2  = (r_rem > N_WIDTH'(2));
    assign o_sts.div_busy = div_busy;
    assign o_sts.div_done = div_done;
    assign o_sts.d_gt_q   = (r_d > quotient);
    assign o_sts.r_zero   = (remainder == '0);
    assign o_sts.pend_v   = r_pend_v;
    assign o_sts.can_emit = !r_pend_v || out_free;
    assign o_sts.cap_next = (r_cnt == CNT_W'(MAX_RESULTS - 1));

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = TDATA_W'(r_out_data);
    assign o_m_tlast  = r_out_last;

endmodule

// File: rtl/core/dpf_ctrl.sv
// Controller state machine that sequences trial division and factor output.
`timescale 1ns / 1ps

module dpf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  dpf_pkg::t_sts i_sts,
    output dpf_pkg::t_cmd o_cmd
);
    import dpf_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_START  = 7'b0000010,
        S_STRIP  = 7'b0000100,
        S_DSTART = 7'b0001000,
        S_DIV    = 7'b0010000,
        S_CHECK  = 7'b0100000,
        S_FINAL  = 7'b1000000
    } t_state;

    // Flushing shares the idle-bound path through a separate flag.
    t_state r_state, n_state;
    logic   r_dout, n_dout;
    logic   r_flush, n_flush;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dout  <= 1'b0;
            r_flush <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dout  <= n_dout;
            r_flush <= n_flush;
        end
    end

    assign o_s_tready = (r_state == S_IDLE) && !r_flush;

    always_comb begin
        n_state = r_state;
        n_dout  = r_dout;
        n_flush = r_flush;
        o_cmd   = '0;
        o_cmd.emit_sel = EMIT_D;

        if (r_flush) begin
            // The last pending factor leaves with the end-of-run mark.
            if (!i_sts.pend_v) begin
                n_flush = 1'b0;
                n_state = S_IDLE;
            end else if (i_sts.can_emit) begin
                o_cmd.flush = 1'b1;
                n_flush     = 1'b0;
                n_state     = S_IDLE;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        o_cmd.load = 1'b1;
                        n_dout     = 1'b0;
                        n_state    = S_START;
                    end
                end
                S_START: begin
                    if (i_sts.rem_zero) begin
                        n_state = S_IDLE;
                    end else if (i_sts.rem_one) begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.emit_sel = EMIT_ONE;
                        n_flush        = 1'b1;
                    end else if (i_sts.rem_even) begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.emit_sel = EMIT_TWO;
                        n_state        = S_STRIP;
                    end else begin
                        n_state = S_DSTART;
                    end
                end
                S_STRIP: begin
                    if (i_sts.rem_even) begin
                        o_cmd.shift = 1'b1;
                    end else begin
                        n_state = S_DSTART;
                    end
                end
                S_DSTART: begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
                S_DIV: begin
                    if (i_sts.div_done) begin
                        n_state = S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (r_dout) begin
                        if (i_sts.r_zero) begin
                            o_cmd.rem_q = 1'b1;
                        end else begin
                            o_cmd.d_inc = 1'b1;
                            n_dout      = 1'b0;
                        end
                        n_state = S_DSTART;
                    end else if (i_sts.d_gt_q) begin
                        n_state = S_FINAL;
                    end else if (i_sts.r_zero) begin
                        if (i_sts.can_emit) begin
                            o_cmd.emit     = 1'b1;
                            o_cmd.emit_sel = EMIT_D;
                            o_cmd.rem_q    = 1'b1;
                            n_dout         = 1'b1;
                            if (i_sts.cap_next) begin
                                n_flush = 1'b1;
                            end else begin
                                n_state = S_DSTART;
                            end
                        end
                    end else begin
                        o_cmd.d_inc = 1'b1;
                        n_state     = S_DSTART;
                    end
                end
                S_FINAL: begin
                    if (!i_sts.rem_gt2) begin
                        n_flush = 1'b1;
                    end else if (i_sts.can_emit) begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.emit_sel = EMIT_REM;
                        n_flush        = 1'b1;
                    end
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: rtl/core/distinct_prime_factors_top.sv
// Top level of the trial-division distinct prime factorizer.
`timescale 1ns / 1ps

//  Channel  | Direction | Payload                         | Transaction
//  ---------+-----------+---------------------------------+-------------------------------
//  s (in)   | input     | tdata[31:0] = value             | one integer to factor
//  m (out)  | output    | tdata[31:0] = factor, tlast     | one distinct prime (or 1), ascending
//
// One value is worked on at a time. Each trial divisor costs one pass of the
// shared bit-serial divider, and so does each time a factor is divided out;
// trailing zero bits are shifted off one at a time before that. Reset is
// synchronous and active low; it returns the controller to idle and drops any
// pending or presented factor. A stalled output only holds the block when a
// new factor must move into the full output register.

module distinct_prime_factors_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [dpf_pkg::TDATA_W-1:0] i_s_tdata,   // [31:0] value
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [dpf_pkg::TDATA_W-1:0] o_m_tdata,   // [31:0] factor
    output logic                        o_m_tlast
);
    import dpf_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // The controller decides each step; the datapath holds every value.
    dpf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // The factor found last is held back one step so that the final factor
    // can carry tlast once the search is known to be over.
    dpf_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_value    (i_s_tdata[N_WIDTH-1:0]),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

`ifndef SYNTHESIS
    // A new value is only taken once the previous run has left nothing pending.
    a_accept_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> !sts.pend_v)
        else $error("input accepted while a factor is still pending");

    // The divider is never restarted in the middle of a division.
    a_div_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.div_start |-> !sts.div_busy)
        else $error("divider restarted while busy");

    // A presented factor is never zero.
    a_factor_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata != '0))
        else $error("zero factor presented");

    // A flush always has a pending factor and room in the output register.
    a_flush_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.flush |-> (sts.pend_v && sts.can_emit))
        else $error("flush without pending factor or output room");
`endif

endmodule

// File: test/testbench.sv
// Self-checking testbench for the trial-division distinct prime factorizer.
`timescale 1ns / 1ps

// What is tested:
//   Every value that the input stream accepts is factored again inside the
//   testbench by plain trial division, and the distinct primes that it should
//   produce are queued in ascending order. The last one is flagged. Each
//   transaction on the output stream is compared field by field (factor, then
//   tlast) with the oldest queued prime.
//
// How:
//   A short directed pass covers the corners: the ignored zero, the single
//   result for 1, pure powers of two and three, squares that hit the d*d == rem
//   boundary, the all-ones word, the product of the first nine primes, and a
//   prime that is left over after the trial loop. Random values follow. Most of
//   them are built from small factors, so that they span the full 32-bit range
//   while the trial loop stays short. A 32-bit prime is never drawn. The sender
//   works in bursts, the receiver stalls on patterns of its own, and twice it
//   holds off for a long stretch while values keep coming. A watchdog ends the
//   run if no transaction moves for too long.

typedef struct {
    bit [dpf_pkg::N_WIDTH-1:0] factor;
    bit                        last;
} t_prime;

class factor_board;
    t_prime due_q[$];    // primes still to come out, oldest first
    t_prime fresh_q[$];  // primes of the value being factored
    int     errors;

    function new();
        errors = 0;
    endfunction

    function void add_prime(bit [dpf_pkg::N_WIDTH-1:0] f);
        t_prime p;
        p.factor = f;
        p.last   = 1'b0;
        fresh_q.push_back(p);
    endfunction

    // Factors an accepted value and queues its distinct primes.
    function void note_value(bit [dpf_pkg::N_WIDTH-1:0] value);
        bit [dpf_pkg::N_WIDTH-1:0] rem;
        bit [dpf_pkg::N_WIDTH-1:0] d;
        rem = value;
        fresh_q.delete();
        // Zero has no factorization and gives nothing.
        if (rem == 0) return;
        if (rem == 1) begin
            add_prime(1);
        end else begin
            if (!rem[0]) begin
                add_prime(2);
                while (!rem[0]) rem = rem >> 1;
            end
            // The square test is written as d <= rem / d so it cannot overflow.
            for (d = 3; fresh_q.size() < dpf_pkg::MAX_RESULTS && d <= rem / d; d += 2) begin
                if (rem % d == 0) begin
                    add_prime(d);
                    while (rem % d == 0) rem = rem / d;
                end
            end
            if (fresh_q.size() < dpf_pkg::MAX_RESULTS && rem > 2) add_prime(rem);
        end
        fresh_q[fresh_q.size() - 1].last = 1'b1;
        foreach (fresh_q[k]) due_q.push_back(fresh_q[k]);
    endfunction

    task report(string msg);
        errors++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_factor(bit [dpf_pkg::N_WIDTH-1:0] factor, bit last);
        t_prime want;
        if (due_q.size() == 0) begin
            report($sformatf("factor %0d (tlast %0b) with nothing outstanding", factor, last));
        end else begin
            want = due_q.pop_front();
            if (factor != want.factor)
                report($sformatf("factor %0d, wanted %0d", factor, want.factor));
            if (last != want.last)
                report($sformatf("tlast %0b on factor %0d, wanted %0b",
                                 last, factor, want.last));
        end
    endtask

    function int pending();
        return due_q.size();
    endfunction
endclass

module testbench;
    import dpf_pkg::*;

    localparam int RANDOM_ITEMS = 80;
    // Longest stretch with no transaction on either side before the run is
    // declared hung.
    localparam int STALL_LIMIT  = 100_000;
    // Cycles the receiver holds off when the pressure test asks for it.
    localparam int LONG_HOLD    = 3000;
    // Quiet time after the last expected factor, to catch stray output.
    localparam int TAIL_CYCLES  = 500;

    // Receiver stall patterns.
    localparam int SINK_OPEN    = 0;  // always ready
    localparam int SINK_COIN    = 1;  // ready half of the time
    localparam int SINK_TRICKLE = 2;  // ready with a chance of one in eight
    localparam int SINK_BEAT    = 3;  // stalls when the phase count is a multiple of three

    logic               i_clk;
    logic               i_rst_n    = 1'b0;
    logic               i_s_tvalid = 1'b0;
    logic               o_s_tready;
    logic [TDATA_W-1:0] i_s_tdata  = '0;   // [31:0] value
    logic               o_m_tvalid;
    logic               i_m_tready = 1'b0;
    logic [TDATA_W-1:0] o_m_tdata;         // [31:0] factor
    logic               o_m_tlast;

    factor_board board = new();

    int hold_req   = 0;  // bumped by the sender to ask for a long hold-off
    int burst_left = 0;
    int quiet_cycles = 0;

    distinct_prime_factors_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Offers one value and returns at the edge where the transaction happens.
    // Outputs are read right after the edge, so they still hold the values
    // that the block presented at that edge.
    task send_value(bit [N_WIDTH-1:0] v);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= TDATA_W'(v);
        do @(posedge i_clk); while (!o_s_tready);
        board.note_value(v);
    endtask

    // Sends in bursts of random length with random gaps in between.
    task offer(bit [N_WIDTH-1:0] v);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 10);
        end
        send_value(v);
        burst_left--;
    endtask

    // Stops sending until every outstanding factor has come out.
    task drain();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (board.pending() != 0);
    endtask

    // Random value. Most are products of small numbers, which reach the top
    // bits yet keep the trial loop short; some carry an odd number up to 2^20 + 1.
    function bit [N_WIDTH-1:0] random_value();
        longint unsigned p;
        longint unsigned f;
        int              kind;
        int              n;
        kind = $urandom_range(0, 19);
        if (kind == 0) return '0;
        if (kind == 1) return N_WIDTH'($urandom_range(1, 2));
        if (kind <= 3) begin
            p = longint'($urandom_range(1, 1 << 20)) | 1;
            return N_WIDTH'(p << $urandom_range(0, 11));
        end
        if (kind <= 8) return N_WIDTH'($urandom_range(1, 65535));
        p = 1;
        n = $urandom_range(1, 10);
        repeat (n) begin
            f = 64'($urandom_range(2, 300));
            if (p * f <= 64'hFFFF_FFFF) p = p * f;
        end
        return N_WIDTH'(p);
    endfunction

    // Receiver: checks each transaction and then picks its next tready.
    initial begin : result_sink
        int hold_left;
        int hold_done;
        int mode;
        int mode_left;
        int phase;
        hold_left = 0;
        hold_done = 0;
        mode      = SINK_OPEN;
        mode_left = 0;
        phase     = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready)
                board.check_factor(o_m_tdata[N_WIDTH-1:0], o_m_tlast);
            if (hold_req != hold_done) begin
                hold_done = hold_req;
                hold_left = LONG_HOLD;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(SINK_OPEN, SINK_BEAT);
                mode_left = $urandom_range(20, 400);
            end
            mode_left--;
            phase++;
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                case (mode)
                    SINK_OPEN:    i_m_tready <= 1'b1;
                    SINK_COIN:    i_m_tready <= 1'($urandom_range(0, 1));
                    SINK_TRICKLE: i_m_tready <= ($urandom_range(0, 7) == 0);
                    default:      i_m_tready <= (phase % 3 != 0);
                endcase
            end
        end
    end

    // Watchdog: counts cycles in which neither side moves a transaction.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[%0t] no transaction for %0d cycles, %0d factors outstanding",
                     $time, STALL_LIMIT, board.pending());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin : stimulus
        bit [N_WIDTH-1:0] corner_q[$];
        bit [N_WIDTH-1:0] v;
        int               sent;
        bit               midway_done;

        corner_q = '{
            32'd0,           // ignored, nothing comes out
            32'd1,           // the single result 1
            32'd2,
            32'd3,
            32'd4,
            32'd6,           // 2, then 3 left over after the loop
            32'd9,
            32'd15,          // 3 found in the loop, 5 left over
            32'd25,          // divisor squared equals the remainder
            32'd98,          // 2 times a prime square
            32'd0,
            32'd1,
            32'h8000_0000,   // pure power of two, top bit set
            32'hFFFF_FFFF,   // 3 * 5 * 17 * 257 * 65537
            32'hFFFF_0000,
            32'hFFF0_0000,
            32'd223092870,   // product of the first nine primes
            32'd3486784401,  // 3 to the 20th
            32'd196611,      // 3 * 65537
            32'd1040399,     // 1019 * 1021, both large
            32'd1048573      // prime just below 2^20
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (corner_q[k]) offer(corner_q[k]);
        // Let everything out before the random part starts.
        drain();

        // The receiver holds off for a long stretch while values keep coming,
        // so the output side fills and the input stalls.
        hold_req <= hold_req + 1;
        sent        = 0;
        midway_done = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            v = random_value();
            offer(v);
            if (v != 0) sent++;
            if (!midway_done && sent == RANDOM_ITEMS / 2) begin
                midway_done = 1'b1;
                drain();
                hold_req <= hold_req + 1;
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
